@@ rtl/core/i2cms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Shared constants, status codes and the structs that pass between the
// controller and the top level.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 256;

    // Item kinds carried in the input tuser field.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;

    // Bus engine status codes.
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
    localparam logic [7:0] ST_ADDR_R_NACK  = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK   = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK  = 8'h58;

    // Transfer end codes.
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_ADDR_W_NACK = 3'd1;
    localparam logic [2:0] ERR_DATA_NACK   = 3'd2;
    localparam logic [2:0] ERR_ARB_LOST    = 3'd3;
    localparam logic [2:0] ERR_ADDR_R_NACK = 3'd4;
    localparam logic [2:0] ERR_RX_NACK     = 3'd5;

    // Result of one item; the transmit byte may still come from the buffer.
    typedef struct packed {
        logic       issue_start;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_from_mem;
        logic       tx_in_range;
        logic       set_ack;
        logic       send_stop;
        logic       clear_start;
        logic       transfer_done;
        logic [2:0] error_code;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       busy_res;
    } res_t;

    // Buffer access request of one item.
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [7:0] rd_addr;
    } mem_req_t;

endpackage

@@ rtl/core/i2cms_buffer_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer byte buffer
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module i2cms_buffer_ram #(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/i2cms_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer controller
// Decodes each item, updates the transfer state and requests buffer accesses.
// ----------------------------------------------------------------------------
module i2cms_ctrl
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [1:0] mode,
    input  logic [7:0] status_code,
    input  logic [7:0] received_byte,
    input  logic [6:0] slave_address,
    input  logic       read_not_write,
    input  logic [7:0] transfer_length,
    input  logic [7:0] load_index,
    input  logic [7:0] load_byte,
    output res_t       res,
    output mem_req_t   mem_req
);

    localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

    logic [7:0] position_reg, position_next;
    logic [7:0] target_reg, target_next;
    logic [7:0] length_reg, length_next;
    logic       busy_reg, busy_next;

    logic       pos_in_range;
    logic       pos_at_end;
    logic [7:0] length_sat;

    assign pos_in_range = {1'b0, position_reg} < DEPTH_W;
    assign pos_at_end   = position_reg == length_reg;
    assign length_sat   = ({1'b0, transfer_length} > DEPTH_W) ? DEPTH_W[7:0]
                                                              : transfer_length;

    always_comb begin
        res           = '0;
        mem_req       = '0;
        position_next = position_reg;
        target_next   = target_reg;
        length_next   = length_reg;
        busy_next     = busy_reg;

        case (mode)
            MODE_LOAD: begin
                mem_req.wr_en   = {1'b0, load_index} < DEPTH_W;
                mem_req.wr_addr = load_index;
                mem_req.wr_data = load_byte;
            end
            MODE_START: begin
                if (!busy_reg) begin
                    target_next     = {slave_address, read_not_write};
                    length_next     = length_sat;
                    busy_next       = 1'b1;
                    res.issue_start = 1'b1;
                end
            end
            MODE_STATUS: begin
                case (status_code)
                    ST_START, ST_RESTART: begin
                        res.tx_valid  = 1'b1;
                        res.tx_byte   = target_reg;
                        res.set_ack   = 1'b1;
                        position_next = '0;
                    end
                    ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
                        if (pos_at_end) begin
                            busy_next         = 1'b0;
                            res.send_stop     = 1'b1;
                            res.clear_start   = 1'b1;
                            res.transfer_done = 1'b1;
                            res.error_code    = ERR_NONE;
                        end else begin
                            // Data byte comes out of the registered buffer read port with the result.
                            res.tx_valid    = 1'b1;
                            res.tx_from_mem = 1'b1;
                            res.tx_in_range = pos_in_range;
                            res.set_ack     = 1'b1;
                            res.clear_start = status_code == ST_ADDR_W_ACK;
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = position_reg;
                            position_next   = position_reg + 8'd1;
                        end
                    end
                    ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ARB_LOST,
                    ST_ADDR_R_NACK, ST_DATA_R_NACK: begin
                        busy_next         = 1'b0;
                        res.send_stop     = 1'b1;
                        res.clear_start   = 1'b1;
                        res.transfer_done = 1'b1;
                        case (status_code)
                            ST_ADDR_W_NACK: res.error_code = ERR_ADDR_W_NACK;
                            ST_DATA_W_NACK: res.error_code = ERR_DATA_NACK;
                            ST_ARB_LOST:    res.error_code = ERR_ARB_LOST;
                            ST_ADDR_R_NACK: res.error_code = ERR_ADDR_R_NACK;
                            default:        res.error_code = ERR_RX_NACK;
                        endcase
                    end
                    ST_ADDR_R_ACK: begin
                        res.set_ack     = 1'b1;
                        res.clear_start = 1'b1;
                    end
                    ST_DATA_R_ACK: begin
                        if (pos_at_end) begin
                            busy_next         = 1'b0;
                            res.send_stop     = 1'b1;
                            res.clear_start   = 1'b1;
                            res.transfer_done = 1'b1;
                            res.error_code    = ERR_NONE;
                        end else begin
                            mem_req.wr_en   = pos_in_range;
                            mem_req.wr_addr = position_reg;
                            mem_req.wr_data = received_byte;
                            res.rx_valid    = 1'b1;
                            res.rx_byte     = received_byte;
                            res.rx_index    = position_reg;
                            res.set_ack     = 1'b1;
                            position_next   = position_reg + 8'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        res.busy_res = busy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            target_reg   <= '0;
            length_reg   <= '0;
            busy_reg     <= 1'b0;
        end else if (accept) begin
            position_reg <= position_next;
            target_reg   <= target_next;
            length_reg   <= length_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

@@ rtl/core/i2c_master_transfer_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Turns load, start and bus engine status items into bus engine commands.
// ----------------------------------------------------------------------------
// Every input item produces exactly one result item. The block takes one item
// per clock cycle while the output is not stalled: an item is decoded in the
// cycle it is accepted, the transfer state registers and the byte buffer are
// updated at that edge, and the result sits in a single output stage on the
// next cycle. A data byte to send is read from the synchronous byte buffer at
// the acceptance edge, so it appears in that same output stage. The input stays
// ready while the output stage is empty or being taken, so throughput is one
// item per cycle unless the output stalls. The buffer has no reset; a byte read
// from an entry that was never loaded or received is undefined.
module i2c_master_transfer_sequencer_unit
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] status_code, [15:8] received_byte, [22:16] slave_address,
    // [23] read_not_write, [31:24] transfer_length, [39:32] load_index,
    // [47:40] load_byte
    input  logic [47:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] issue_start, [1] tx_valid, [9:2] tx_byte, [10] set_ack,
    // [11] send_stop, [12] clear_start, [13] transfer_done,
    // [16:14] error_code, [17] rx_valid, [25:18] rx_byte, [33:26] rx_index,
    // [34] busy_res, [39:35] zero
    output logic [39:0] m_axis_tdata
);

    localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic     accept;
    res_t     res;
    res_t     res_reg;
    mem_req_t mem_req;
    logic     out_valid_reg;
    logic [7:0] rd_data;
    logic [7:0] tx_byte_out;

    // The output stage frees up in the same cycle its item is taken.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    i2cms_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .mode            (s_axis_tuser),
        .status_code     (s_axis_tdata[7:0]),
        .received_byte   (s_axis_tdata[15:8]),
        .slave_address   (s_axis_tdata[22:16]),
        .read_not_write  (s_axis_tdata[23]),
        .transfer_length (s_axis_tdata[31:24]),
        .load_index      (s_axis_tdata[39:32]),
        .load_byte       (s_axis_tdata[47:40]),
        .res             (res),
        .mem_req         (mem_req)
    );

    // Writes and reads both happen at the acceptance edge of their item, so a
    // read always sees every write made by earlier items; no forwarding needed.
    // The read port only moves on acceptance, which holds the data of a stalled
    // result steady.
    i2cms_buffer_ram #(
        .DEPTH(BUFFER_DEPTH)
    ) u_buffer (
        .aclk    (aclk),
        .wr_en   (accept && mem_req.wr_en),
        .wr_addr (mem_req.wr_addr[BUF_AW-1:0]),
        .wr_data (mem_req.wr_data),
        .rd_en   (accept && mem_req.rd_en),
        .rd_addr (mem_req.rd_addr[BUF_AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    // A position past the end of the buffer sends a zero byte.
    always_comb begin
        if (res_reg.tx_from_mem) begin
            tx_byte_out = res_reg.tx_in_range ? rd_data : 8'd0;
        end else begin
            tx_byte_out = res_reg.tx_byte;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0,
                            res_reg.busy_res,
                            res_reg.rx_index,
                            res_reg.rx_byte,
                            res_reg.rx_valid,
                            res_reg.error_code,
                            res_reg.transfer_done,
                            res_reg.clear_start,
                            res_reg.send_stop,
                            res_reg.set_ack,
                            tx_byte_out,
                            res_reg.tx_valid,
                            res_reg.issue_start};

endmodule
